// ===== design/ffba_pkg.sv =====
package ffba_pkg;

	// Default number of managed blocks.
	localparam int NUM_BLOCKS_DEF = 16;

	// Depth of the command queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// Request types.
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMEM   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	// Command kinds as classified by the front.
	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_FREE    = 2'd1;
	localparam logic [1:0] CMD_NOMEM   = 2'd2;
	localparam logic [1:0] CMD_INVALID = 2'd3;

	// One classified request as it travels through the queue.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] want;
		logic [7:0] id;
	} cmd_t;

endpackage

// ===== design/ffba_ram.sv =====
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/ffba_front.sv =====
module ffba_front
	import ffba_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] req_blocks,
	input  logic [7:0] alloc_id,
	output cmd_t       cmd,
	output logic       cmd_valid,
	input  logic       cmd_pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t            q_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     cnt_q;
	cmd_t            cls;
	logic            push;

	// Classify the request on checks that need no allocator state.
	always_comb begin
		cls.want = req_blocks;
		cls.id   = alloc_id;
		if (req_type == REQ_ALLOC) begin
			if (req_blocks == 8'd0) begin
				cls.kind = CMD_INVALID;
			end else if (req_blocks > 8'(NUM_BLOCKS)) begin
				cls.kind = CMD_NOMEM;
			end else begin
				cls.kind = CMD_ALLOC;
			end
		end else begin
			if (alloc_id == 8'd0) begin
				cls.kind = CMD_INVALID;
			end else begin
				cls.kind = CMD_FREE;
			end
		end
	end

	assign in_ready  = (cnt_q != (PW+1)'(QUEUE_DEPTH));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_q[rd_ptr_q];

	// Command queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PW'(wr_ptr_q + 1'b1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= PW'(rd_ptr_q + 1'b1);
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/ffba_back.sv =====
module ffba_back
	import ffba_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic       cmd_valid,
	output logic       cmd_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [3:0] start_block,
	output logic [4:0] live_count
);

	localparam int IW = $clog2(NUM_BLOCKS);
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int RW = IW + CW;
	localparam logic [IW-1:0] LAST_BLOCK = IW'(NUM_BLOCKS - 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_ACOMMIT = 3'd2;
	localparam logic [2:0] S_FREAD   = 3'd3;
	localparam logic [2:0] S_SHIFT   = 3'd4;

	logic [2:0]            state_q;
	logic [NUM_BLOCKS-1:0] occ_q;
	logic [CW-1:0]         count_q;
	logic [IW-1:0]         idx_q;
	logic [CW-1:0]         run_q;
	logic [CW-1:0]         want_q;
	logic [IW-1:0]         start_q;
	logic                  res_valid_q;
	logic [1:0]            res_status_q;
	logic [3:0]            res_start_q;
	logic [4:0]            res_count_q;

	logic [CW-1:0]         want_n;
	logic [IW-1:0]         pos_n;
	logic                  id_too_big;
	logic [CW-1:0]         run_inc;
	logic                  hit;
	logic [CW:0]           start_wide;
	logic [CW-1:0]         nxt;
	logic                  more;
	logic                  ram_we;
	logic [IW-1:0]         ram_waddr;
	logic [RW-1:0]         ram_wdata;
	logic [IW-1:0]         ram_raddr;
	logic [RW-1:0]         ram_rdata;
	logic [IW-1:0]         rec_start;
	logic [CW-1:0]         rec_len;

	// Mask of n consecutive blocks starting at block s, cut at the top block.
	function automatic logic [NUM_BLOCKS-1:0] run_mask(input logic [IW-1:0] s,
		input logic [CW-1:0] n);
		logic [2*NUM_BLOCKS-1:0] w;
		w = ((2*NUM_BLOCKS)'(1) << n) - (2*NUM_BLOCKS)'(1);
		w = w << s;
		return w[NUM_BLOCKS-1:0];
	endfunction

	function automatic logic [3:0] to_start(input logic [IW-1:0] s);
		logic [IW+3:0] w;
		w = (IW+4)'(s);
		return w[3:0];
	endfunction

	function automatic logic [4:0] to_count(input logic [CW-1:0] c);
		logic [CW+4:0] w;
		w = (CW+5)'(c);
		return w[4:0];
	endfunction

	// Decode of the queue head and of the scan and shift steps.
	assign want_n     = cmd.want[CW-1:0];
	assign pos_n      = IW'(cmd.id - 8'd1);
	assign id_too_big = (9'(cmd.id) > 9'(count_q));
	assign run_inc    = run_q + 1'b1;
	assign hit        = !occ_q[idx_q] && (run_inc == want_q);
	assign start_wide = (CW+1)'(idx_q) + (CW+1)'(1) - (CW+1)'(want_q);
	assign nxt        = CW'(idx_q) + 1'b1;
	assign more       = (nxt < count_q);
	assign rec_start  = ram_rdata[RW-1:CW];
	assign rec_len    = ram_rdata[CW-1:0];

	assign cmd_pop     = (state_q == S_IDLE) && cmd_valid && !res_valid_q;
	assign out_valid   = res_valid_q;
	assign status      = res_status_q;
	assign start_block = res_start_q;
	assign live_count  = res_count_q;

	// Record table port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q - 1'b1;
		ram_wdata = ram_rdata;
		ram_raddr = nxt[IW-1:0];
		unique case (state_q)
			S_IDLE: begin
				ram_raddr = pos_n;
			end
			S_ACOMMIT: begin
				ram_we    = 1'b1;
				ram_waddr = count_q[IW-1:0];
				ram_wdata = {start_q, want_q};
			end
			S_SHIFT: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	ffba_ram #(
		.WIDTH(RW),
		.DEPTH(NUM_BLOCKS)
	) u_rec_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Request sequencer with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			occ_q        <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			run_q        <= '0;
			want_q       <= '0;
			start_q      <= '0;
			res_valid_q  <= 1'b0;
			res_status_q <= ST_OK;
			res_start_q  <= '0;
			res_count_q  <= '0;
		end else begin
			if (res_valid_q && out_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						res_start_q <= '0;
						res_count_q <= to_count(count_q);
						unique case (cmd.kind)
							CMD_INVALID: begin
								res_valid_q  <= 1'b1;
								res_status_q <= ST_INVALID;
							end
							CMD_NOMEM: begin
								res_valid_q  <= 1'b1;
								res_status_q <= ST_NOMEM;
							end
							CMD_ALLOC: begin
								if (count_q >= CW'(NUM_BLOCKS)) begin
									res_valid_q  <= 1'b1;
									res_status_q <= ST_NOMEM;
								end else begin
									want_q  <= want_n;
									idx_q   <= '0;
									run_q   <= '0;
									state_q <= S_SCAN;
								end
							end
							CMD_FREE: begin
								if (id_too_big) begin
									res_valid_q  <= 1'b1;
									res_status_q <= ST_INVALID;
								end else begin
									idx_q   <= pos_n;
									state_q <= S_FREAD;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					// One block per cycle, lowest first.
					run_q <= occ_q[idx_q] ? '0 : run_inc;
					if (hit) begin
						start_q <= start_wide[IW-1:0];
						state_q <= S_ACOMMIT;
					end else if (idx_q == LAST_BLOCK) begin
						res_valid_q  <= 1'b1;
						res_status_q <= ST_NOMEM;
						res_start_q  <= '0;
						res_count_q  <= to_count(count_q);
						state_q      <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_ACOMMIT: begin
					occ_q        <= occ_q | run_mask(start_q, want_q);
					count_q      <= count_q + 1'b1;
					res_valid_q  <= 1'b1;
					res_status_q <= ST_OK;
					res_start_q  <= to_start(start_q);
					res_count_q  <= to_count(count_q + 1'b1);
					state_q      <= S_IDLE;
				end
				S_FREAD, S_SHIFT: begin
					// Release the blocks once, then move later records down.
					if (state_q == S_FREAD) begin
						occ_q <= occ_q & ~run_mask(rec_start, rec_len);
					end
					if (more) begin
						idx_q   <= nxt[IW-1:0];
						state_q <= S_SHIFT;
					end else begin
						count_q      <= count_q - 1'b1;
						res_valid_q  <= 1'b1;
						res_status_q <= ST_OK;
						res_start_q  <= '0;
						res_count_q  <= to_count(count_q - 1'b1);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/first_fit_block_allocator.sv =====
// First-fit contiguous block allocator over NUM_BLOCKS blocks. An allocate
// request takes the lowest run of free blocks of the asked length and appends
// a record to the live table; a free request names a record by its 1-based
// position, releases its blocks and renumbers the records above it. Every
// request returns exactly one result. Requests pass through a two-entry
// queue, so up to two further requests are taken while a result waits at
// the output. An allocate scans the occupancy map one block per cycle; a
// free moves each record above the freed one down a place, one record a
// cycle, since the record table is a single-port-read, single-port-write
// RAM. The engine starts the next request in the cycle after the result
// transfer, so a stalled output stalls the engine cycle for cycle.
// The occupancy map and record count clear at reset; no clearing pass runs.
module first_fit_block_allocator
	import ffba_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] req_blocks,
	input  logic [7:0] alloc_id,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [3:0] start_block,
	output logic [4:0] live_count
);

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;

	// Request intake, classification and queue.
	ffba_front #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.req_blocks(req_blocks),
		.alloc_id  (alloc_id),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	// Allocation engine and result register.
	ffba_back #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.start_block(start_block),
		.live_count (live_count)
	);

endmodule

// ===== design/ffba_checker.sv =====
module ffba_checker
	import ffba_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [3:0] start_block,
	input logic [4:0] live_count
);

	logic [4:0] last_count_q;
	logic       xfer;

	assign xfer = out_valid && out_ready;

	// Live count as of the last result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q <= '0;
		end else if (xfer) begin
			last_count_q <= live_count;
		end
	end

	// A waiting result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(start_block) && $stable(live_count))
		else $error("result changed while stalled");

	// A failed request reports block zero.
	a_fail_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> start_block == 4'd0)
		else $error("failed request with nonzero start block");

	// A failed request leaves the record count alone.
	a_fail_count: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && status != ST_OK |-> live_count == last_count_q)
		else $error("failed request changed the live count");

	// A successful request adds or removes exactly one record.
	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && status == ST_OK |-> live_count == 5'(last_count_q + 5'd1)
			|| live_count == 5'(last_count_q - 5'd1))
		else $error("successful request moved the live count by other than one");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.start_block(start_block),
	.live_count (live_count)
);

// ===== tb/sv/testbench.sv =====
module testbench;
	import ffba_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBLK = NUM_BLOCKS_DEF;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;

	// One result as the allocator should return it.
	typedef struct {
		logic [1:0] status;
		logic [3:0] start;
		logic [4:0] live;
	} alloc_reply_t;

	// Receiver stall patterns.
	typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       req_type;
	logic [7:0] req_blocks;
	logic [7:0] alloc_id;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] status;
	logic [3:0] start_block;
	logic [4:0] live_count;

	// Predicted allocator state.
	logic [NBLK-1:0] occ_map;
	logic [3:0]      rec_first [NBLK];
	logic [4:0]      rec_len [NBLK];
	int              live_records;

	alloc_reply_t reply_queue[$];
	alloc_reply_t want_reply;

	int error_count = 0;
	int burst_left;
	int idle_cycles = 0;
	int rx_cycle = 0;
	int rx_stall_left = 0;
	rx_mode_t rx_mode = RX_ALWAYS;

	// Coverage tallies for the summary.
	int n_requests;
	int n_alloc_ok;
	int n_free_ok;
	int n_nomem;
	int n_invalid;
	int n_full_map;
	int peak_live;

	first_fit_block_allocator #(
		.NUM_BLOCKS(NBLK)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.req_blocks(req_blocks),
		.alloc_id(alloc_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.start_block(start_block),
		.live_count(live_count)
	);

	// Clock generation.
	always #4 clk = ~clk;

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, exp_val);
		error_count++;
	endtask

	// Applies one accepted request to the predicted state and queues its result.
	task automatic predict_reply(input logic rt, input logic [7:0] nb, input logic [7:0] id);
		alloc_reply_t r;
		int run;
		int first;
		int pos;
		int i;
		bit found;
		r.status = ST_OK;
		r.start = '0;
		n_requests++;
		if (rt == REQ_ALLOC) begin
			if (nb == 0) begin
				r.status = ST_INVALID;
			end else if (nb > NBLK || live_records >= NBLK) begin
				r.status = ST_NOMEM;
			end else begin
				// First fit: the lowest run of free blocks that is long enough.
				run = 0;
				first = 0;
				found = 1'b0;
				for (i = 0; i < NBLK && !found; i++) begin
					if (occ_map[i]) begin
						run = 0;
					end else begin
						run++;
						if (run == nb) begin
							first = i + 1 - nb;
							found = 1'b1;
						end
					end
				end
				if (!found) begin
					r.status = ST_NOMEM;
				end else begin
					for (i = first; i < first + nb; i++)
						occ_map[i] = 1'b1;
					rec_first[live_records] = 4'(first);
					rec_len[live_records] = 5'(nb);
					live_records++;
					r.start = 4'(first);
					n_alloc_ok++;
					if (nb == NBLK)
						n_full_map++;
				end
			end
		end else begin
			if (id == 0 || id > live_records) begin
				r.status = ST_INVALID;
			end else begin
				// Release the blocks and close the gap in the record table.
				pos = id - 1;
				for (i = rec_first[pos]; i < rec_first[pos] + rec_len[pos] && i < NBLK; i++)
					occ_map[i] = 1'b0;
				for (i = pos; i + 1 < live_records; i++) begin
					rec_first[i] = rec_first[i + 1];
					rec_len[i] = rec_len[i + 1];
				end
				live_records--;
				n_free_ok++;
			end
		end
		if (r.status == ST_NOMEM)
			n_nomem++;
		if (r.status == ST_INVALID)
			n_invalid++;
		if (live_records > peak_live)
			peak_live = live_records;
		r.live = 5'(live_records);
		reply_queue.push_back(r);
	endtask

	// Presents one request, idling between bursts, and waits for its transfer.
	task automatic send_request(input logic rt, input logic [7:0] nb, input logic [7:0] id);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		req_type <= rt;
		req_blocks <= nb;
		alloc_id <= id;
		do @(posedge clk); while (!in_ready);
		predict_reply(rt, nb, id);
	endtask

	// Holds the request side idle until every queued result has arrived.
	task automatic wait_for_replies();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (reply_queue.size() != 0);
	endtask

	// Requests that must be rejected on an empty allocator.
	task automatic test_rejects();
		send_request(REQ_ALLOC, 8'd0, 8'hFF);
		send_request(REQ_ALLOC, 8'(NBLK + 1), 8'h00);
		send_request(REQ_ALLOC, 8'hFF, 8'hFF);
		send_request(REQ_FREE, 8'hFF, 8'd0);
		send_request(REQ_FREE, 8'h00, 8'd1);
		wait_for_replies();
	endtask

	// Fills the table with single blocks, then probes the full and fragmented cases.
	task automatic test_table_full();
		int k;
		for (k = 0; k < NBLK; k++)
			send_request(REQ_ALLOC, 8'd1, 8'($urandom));
		send_request(REQ_ALLOC, 8'd1, 8'h00);
		send_request(REQ_FREE, 8'h00, 8'(NBLK + 1));
		send_request(REQ_FREE, 8'hFF, 8'd1);
		send_request(REQ_ALLOC, 8'd2, 8'hFF);
		send_request(REQ_FREE, 8'h00, 8'(NBLK - 1));
		wait_for_replies();
	endtask

	// Frees every record, then takes the whole map in one allocation and frees it again.
	task automatic release_everything();
		while (live_records > 0)
			send_request(REQ_FREE, 8'($urandom), 8'($urandom_range(1, live_records)));
		send_request(REQ_ALLOC, 8'(NBLK), 8'($urandom));
		send_request(REQ_FREE, 8'($urandom), 8'd1);
	endtask

	// Mostly well-formed traffic with some malformed requests mixed in.
	task automatic test_random_traffic(input int count);
		int k;
		int sel;
		int p_free;
		logic [7:0] size;
		for (k = 0; k < count; k++) begin
			if (k == count / 2)
				wait_for_replies();
			if (k % 400 == 399)
				release_everything();
			sel = $urandom_range(0, 99);
			if (sel < 8) begin
				case (sel % 4)
					0: send_request(REQ_ALLOC, 8'd0, 8'($urandom));
					1: send_request(REQ_ALLOC, 8'($urandom), 8'($urandom));
					2: send_request(REQ_FREE, 8'($urandom), 8'd0);
					default: send_request(REQ_FREE, 8'($urandom), 8'($urandom));
				endcase
			end else begin
				p_free = 20 + live_records * 5;
				size = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, NBLK))
					: 8'($urandom_range(1, 5));
				if (live_records > 0 && $urandom_range(0, 99) < p_free)
					send_request(REQ_FREE, 8'($urandom),
						8'($urandom_range(1, live_records)));
				else
					send_request(REQ_ALLOC, size, 8'($urandom));
			end
		end
		wait_for_replies();
	endtask

	// Receiver stall pattern; rx_cycle sets when the mode is picked again at random.
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 256 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_ALWAYS: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			RX_PERIODIC: out_ready <= (rx_cycle % 7) >= 3;
			default: begin
				if (rx_stall_left > 0) begin
					rx_stall_left--;
					out_ready <= 1'b0;
				end else if ($urandom_range(0, 15) == 0) begin
					rx_stall_left = $urandom_range(1, 12);
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		endcase
	end

	// Compares each result transfer with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (reply_queue.size() == 0) begin
				report_mismatch("result with nothing expected, status", status, 0);
			end else begin
				want_reply = reply_queue.pop_front();
				if (status !== want_reply.status)
					report_mismatch("status", status, want_reply.status);
				if (start_block !== want_reply.start)
					report_mismatch("start_block", start_block, want_reply.start);
				if (live_count !== want_reply.live)
					report_mismatch("live_count", live_count, want_reply.live);
			end
		end
	end

	// Ends the run when no transfer happens for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, reply_queue.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_ALLOC;
		req_blocks = '0;
		alloc_id = '0;
		occ_map = '0;
		live_records = 0;
		burst_left = 0;
		n_requests = 0;
		n_alloc_ok = 0;
		n_free_ok = 0;
		n_nomem = 0;
		n_invalid = 0;
		n_full_map = 0;
		peak_live = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_rejects();
		test_table_full();
		test_random_traffic(1700);

		in_valid <= 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d requests: %0d allocations, %0d frees, %0d no-memory, %0d invalid.",
			n_requests, n_alloc_ok, n_free_ok, n_nomem, n_invalid);
		$display("Peak live records %0d; whole-map allocations %0d.", peak_live, n_full_map);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", error_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
